// ===== sv/bdd_pkg.sv =====
// Shared types, request and status codes for the bounded deque with delete.
package bdd_pkg;

    // Field widths and default depth.
    localparam int VALUE_W          = 32;
    localparam int COUNT_IN_W       = 6;
    localparam int REQ_W            = 4;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd4;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 4'd5;
    localparam logic [REQ_W-1:0] REQ_READ_ALL   = 4'd6;
    localparam logic [REQ_W-1:0] REQ_READ_FIRST = 4'd7;
    localparam logic [REQ_W-1:0] REQ_READ_LAST  = 4'd8;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

    // What a cell loads on the next clock.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } cell_op_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        cell_op_t op;
        logic     live;
        logic     flag_clr;
        logic     flag_en;
    } cell_ctrl_t;

endpackage

// ===== sv/bdd_cell.sv =====
// One storage cell of the deque chain with its delete-search flag.
module bdd_cell
    import bdd_pkg::*;
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic signed [VALUE_W-1:0] load_value,
    input  logic signed [VALUE_W-1:0] match_value,
    input  logic signed [VALUE_W-1:0] prev_data,
    input  logic signed [VALUE_W-1:0] next_data,
    input  logic                      flag_prev,
    output logic signed [VALUE_W-1:0] data,
    output logic                      flag
);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;
    logic                      flag_reg;
    logic                      flag_next;
    logic                      hit;

    // Entry select: keep, load, or take a neighbor's entry.
    always_comb
    begin
        unique case (ctrl.op)
            CELL_HOLD: data_next = data_reg;
            CELL_LOAD: data_next = load_value;
            CELL_PREV: data_next = prev_data;
            CELL_NEXT: data_next = next_data;
            default:   data_next = data_reg;
        endcase
    end

    // The flag marks this cell as at or behind the first live match.
    assign hit = ctrl.live && (data_reg == match_value);

    always_comb
    begin
        if (ctrl.flag_clr)
        begin
            flag_next = 1'b0;
        end
        else if (ctrl.flag_en)
        begin
            flag_next = flag_reg | flag_prev | hit;
        end
        else
        begin
            flag_next = flag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        flag_reg <= flag_next;
    end

    assign data = data_reg;
    assign flag = flag_reg;

endmodule

// ===== sv/bounded_deque_with_delete.sv =====
// Top level of the bounded deque with delete: cell chain and request sequencer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  in      | to block  | in_valid/in_stall  | req_type, value, item_count
//  out     | from block| out_valid/out_stall| item_value, has_item, status, last_of_run
//
// Push, pop, clear, unused codes and empty read-outs are answered straight from idle.
// Delete scans the chain, then commits: the match flag ripples one cell per cycle.
// A read-out rotates the ring once; output stalls hold the rotation.
// Reset empties the deque at once; entries need no clearing.
// A stalled output holds the chain where a transfer is pending, and new
// requests wait while the output register is full and stalled.
module bounded_deque_with_delete
    import bdd_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [REQ_W-1:0]           req_type,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [COUNT_IN_W-1:0]      item_count,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [VALUE_W-1:0]  item_value,
    output logic                       has_item,
    output logic [STATUS_W-1:0]        status,
    output logic                       last_of_run
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam int MW = (CW > COUNT_IN_W) ? CW : COUNT_IN_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [SW-1:0] STEP_LAST = SW'(CAPACITY - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_ROTATE = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             occ_reg, occ_next;
    logic [SW-1:0]             step_reg, step_next;
    logic [CW-1:0]             skip_reg, skip_next;
    logic [CW-1:0]             left_reg, left_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] match_reg, match_next;
    logic signed [VALUE_W-1:0] item_value_reg, item_value_next;
    logic                      has_item_reg, has_item_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic                      last_reg, last_next;

    cell_ctrl_t                ctrl [CAPACITY];
    logic signed [VALUE_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]       flags;

    logic                      out_free;
    logic                      accept;
    logic                      load_out;
    logic                      full;
    logic                      empty;
    logic [CW-1:0]             cnt_sat;
    logic [CW-1:0]             rd_start;
    logic [CW-1:0]             rd_cnt;
    logic                      emit;

    // The output register can take a result this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign full     = (occ_reg == CAP_C);
    assign empty    = (occ_reg == '0);

    // Read-out window: counts saturate to the occupancy.
    always_comb
    begin
        if (MW'(item_count) > MW'(occ_reg))
        begin
            cnt_sat = occ_reg;
        end
        else
        begin
            cnt_sat = CW'(item_count);
        end
        rd_start = '0;
        rd_cnt   = occ_reg;
        if (req_type == REQ_READ_FIRST)
        begin
            rd_cnt = cnt_sat;
        end
        else if (req_type == REQ_READ_LAST)
        begin
            rd_cnt   = cnt_sat;
            rd_start = occ_reg - cnt_sat;
        end
    end

    // A rotation step that hands an entry to the output.
    assign emit = (skip_reg == '0) && (left_reg != '0);

    // Sequencer and per-cell control.
    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        step_next       = step_reg;
        skip_next       = skip_reg;
        left_next       = left_reg;
        match_next      = match_reg;
        load_out        = 1'b0;
        item_value_next = '0;
        has_item_next   = 1'b0;
        status_next     = STATUS_OK;
        last_next       = 1'b1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl[i].op       = CELL_HOLD;
            ctrl[i].live     = (CW'(i) < occ_reg);
            ctrl[i].flag_clr = 1'b0;
            ctrl[i].flag_en  = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (req_type)
                        REQ_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    ctrl[i].op = CELL_PREV;
                                end
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (CW'(i) == occ_reg)
                                    begin
                                        ctrl[i].op = CELL_LOAD;
                                    end
                                end
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    ctrl[i].op = CELL_NEXT;
                                end
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            occ_next = '0;
                        end
                        REQ_DELETE:
                        begin
                            load_out   = 1'b0;
                            match_next = value;
                            step_next  = '0;
                            state_next = ST_SCAN;
                            for (int i = 0; i < CAPACITY; i++)
                            begin
                                ctrl[i].flag_clr = 1'b1;
                            end
                        end
                        REQ_READ_ALL, REQ_READ_FIRST, REQ_READ_LAST:
                        begin
                            if (rd_cnt == '0)
                            begin
                                status_next = empty ? STATUS_EMPTY : STATUS_OK;
                            end
                            else
                            begin
                                load_out   = 1'b0;
                                skip_next  = rd_start;
                                left_next  = rd_cnt;
                                step_next  = '0;
                                state_next = ST_ROTATE;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Ripple the match flag one cell further toward the back.
                for (int i = 0; i < CAPACITY; i++)
                begin
                    ctrl[i].flag_en = 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (flags[CAPACITY-1])
                    begin
                        // Close the gap: cells at and behind the match move up.
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (flags[i])
                            begin
                                ctrl[i].op = CELL_NEXT;
                            end
                        end
                        occ_next = occ_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_NOTFOUND;
                    end
                end
            end
            ST_ROTATE:
            begin
                // Rotate the ring once; the front cell feeds the output.
                if (!emit || out_free)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        ctrl[i].op = CELL_NEXT;
                    end
                    if (skip_reg != '0)
                    begin
                        skip_next = skip_reg - 1'b1;
                    end
                    else if (left_reg != '0)
                    begin
                        load_out        = 1'b1;
                        item_value_next = cell_data[0];
                        has_item_next   = 1'b1;
                        last_next       = (left_reg == CW'(1));
                        left_next       = left_reg - 1'b1;
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set by a new result, cleared by a transfer.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            step_reg      <= '0;
            skip_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            step_reg      <= step_next;
            skip_reg      <= skip_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        if (load_out)
        begin
            item_value_reg <= item_value_next;
            has_item_reg   <= has_item_next;
            status_reg     <= status_next;
            last_reg       <= last_next;
        end
    end

    // The cell chain; the back cell wraps to the front for rotation.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [VALUE_W-1:0] prev_d;
        logic signed [VALUE_W-1:0] next_d;
        logic                      flag_p;

        if (g == 0)
        begin : g_front
            assign prev_d = value;
            assign flag_p = 1'b0;
        end
        else
        begin : g_mid
            assign prev_d = cell_data[g-1];
            assign flag_p = flags[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_back
            assign next_d = cell_data[0];
        end
        else
        begin : g_inner
            assign next_d = cell_data[g+1];
        end

        bdd_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl[g]),
            .load_value  (value),
            .match_value (match_reg),
            .prev_data   (prev_d),
            .next_data   (next_d),
            .flag_prev   (flag_p),
            .data        (cell_data[g]),
            .flag        (flags[g])
        );
    end

    assign out_valid   = out_valid_reg;
    assign item_value  = item_value_reg;
    assign has_item    = has_item_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

endmodule

// ===== sv/bdd_checker.sv =====
// Port-level checks for the bounded deque with delete, bound to the top level.
module bdd_checker
    import bdd_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [REQ_W-1:0]          req_type,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [VALUE_W-1:0] item_value,
    input logic                      has_item,
    input logic [STATUS_W-1:0]       status,
    input logic                      last_of_run
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(item_value)
            && $stable(has_item) && $stable(status) && $stable(last_of_run))
        else $error("stalled result changed");

    // Entries from a read-out always carry an ok status.
    a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_item |-> status == STATUS_OK)
        else $error("entry result with non-ok status");

    // A result without an entry is a request's only result and reads as zero.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_item |-> last_of_run && item_value == '0)
        else $error("entry-less result not final or not zero");

    // A delete keeps the block busy while it searches the chain.
    a_delete_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == REQ_DELETE |=> in_stall)
        else $error("request taken during a delete search");

endmodule

bind bounded_deque_with_delete bdd_checker u_bdd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .item_value  (item_value),
    .has_item    (has_item),
    .status      (status),
    .last_of_run (last_of_run)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the bounded deque with delete, with a built-in deque predictor.
module tb_top
    import bdd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 405;
    localparam int CALM_ITEMS   = 60;
    localparam int MAX_REPORTS  = 40;

    // Request codes the block does not use; they must answer with a plain OK.
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 4'd9;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 4'd15;

    // Where a directed row takes its expectation from.
    localparam logic FROM_TABLE = 1'b1;
    localparam logic FROM_MODEL = 1'b0;

    // One result transfer as the output channel carries it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] item;
        logic                      has;
        logic [STATUS_W-1:0]       st;
        logic                      last;
    } result_t;

    // One directed request; the status is used only for rows checked from the table.
    typedef struct packed {
        logic [REQ_W-1:0]          rq;
        logic signed [VALUE_W-1:0] v;
        logic [COUNT_IN_W-1:0]     k;
        logic                      given;
        logic [STATUS_W-1:0]       st;
    } script_row_t;

    localparam int SCRIPT_LEN = 25;

    // Empty-deque requests, extreme values, saturated and zero counts, spare codes,
    // a single-entry pop from the back and a pop from the front ahead of a read-out.
    script_row_t script [SCRIPT_LEN] = '{
        '{REQ_POP_FRONT,  0,             0,  FROM_TABLE, STATUS_EMPTY},
        '{REQ_POP_BACK,   0,             0,  FROM_TABLE, STATUS_EMPTY},
        '{REQ_READ_ALL,   0,             0,  FROM_TABLE, STATUS_EMPTY},
        '{REQ_READ_FIRST, 0,             5,  FROM_TABLE, STATUS_EMPTY},
        '{REQ_DELETE,     0,             0,  FROM_TABLE, STATUS_NOTFOUND},
        '{REQ_PUSH_BACK,  32'sh7FFFFFFF, 0,  FROM_TABLE, STATUS_OK},
        '{REQ_PUSH_FRONT, 32'sh80000000, 0,  FROM_TABLE, STATUS_OK},
        '{REQ_PUSH_BACK,  -1,            0,  FROM_TABLE, STATUS_OK},
        '{REQ_PUSH_FRONT, 0,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_READ_ALL,   0,             0,  FROM_MODEL, STATUS_OK},
        '{REQ_READ_FIRST, 0,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_READ_LAST,  0,             63, FROM_MODEL, STATUS_OK},
        '{REQ_DELETE,     -1,            0,  FROM_TABLE, STATUS_OK},
        '{REQ_DELETE,     12345,         0,  FROM_TABLE, STATUS_NOTFOUND},
        '{REQ_POP_BACK,   0,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_POP_FRONT,  0,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_PUSH_BACK,  1,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_POP_FRONT,  0,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_READ_ALL,   0,             0,  FROM_MODEL, STATUS_OK},
        '{REQ_SPARE_LO,   0,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_SPARE_HI,   -1,            63, FROM_TABLE, STATUS_OK},
        '{REQ_CLEAR,      0,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_PUSH_BACK,  5,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_POP_BACK,   0,             0,  FROM_TABLE, STATUS_OK},
        '{REQ_READ_LAST,  0,             1,  FROM_TABLE, STATUS_EMPTY}
    };

    logic [REQ_W-1:0] readout_codes [3] = '{REQ_READ_ALL, REQ_READ_FIRST, REQ_READ_LAST};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [REQ_W-1:0]           req_type = '0;
    logic signed [VALUE_W-1:0]  value = '0;
    logic [COUNT_IN_W-1:0]      item_count = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [VALUE_W-1:0]  item_value;
    logic                       has_item;
    logic [STATUS_W-1:0]        status;
    logic                       last_of_run;

    // Predicted deque contents and the results still owed by the block.
    logic signed [VALUE_W-1:0]  mirror_store [CAPACITY];
    int unsigned                mirror_head  = 0;
    int unsigned                mirror_count = 0;
    result_t                    owed_results [$];

    // Idling control and run statistics.
    bit                         calm       = 1'b0;
    int unsigned                gap_pct    = 0;
    int unsigned                stall_pct  = 0;
    int unsigned                stall_left = 0;
    int unsigned                n_errors   = 0;
    int unsigned                n_items    = 0;
    int unsigned                n_results  = 0;
    int unsigned                n_readouts = 0;
    int unsigned                n_full     = 0;
    int unsigned                n_missed   = 0;

    bounded_deque_with_delete #(
        .CAPACITY    (CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .value       (value),
        .item_count  (item_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .item_value  (item_value),
        .has_item    (has_item),
        .status      (status),
        .last_of_run (last_of_run)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard limit on run time.
    initial
    begin
        #10_000_000;
        $display("%0t ns: timeout, %0d results still outstanding", $time, owed_results.size());
        $display("bounded_deque_with_delete test failed");
        $finish;
    end

    function automatic result_t make_result(
        input logic signed [VALUE_W-1:0] val,
        input logic                      has,
        input logic [STATUS_W-1:0]       st,
        input logic                      last
    );
        result_t r;
        r.item = val;
        r.has  = has;
        r.st   = st;
        r.last = last;
        return r;
    endfunction

    function automatic int unsigned ring_slot(input int unsigned pos);
        return (mirror_head + pos) % CAPACITY;
    endfunction

    // Advance the predicted deque by one request and list the results it causes.
    function automatic void apply_request(
        input logic [REQ_W-1:0]          rq,
        input logic signed [VALUE_W-1:0] v,
        input logic [COUNT_IN_W-1:0]     k,
        ref   result_t                   outq [$]
    );
        int unsigned         span;
        int unsigned         first;
        bit                  reading;
        bit                  found;
        logic [STATUS_W-1:0] st;

        span    = (k > mirror_count) ? mirror_count : k;
        first   = 0;
        reading = 1'b0;
        found   = 1'b0;
        st      = STATUS_OK;
        case (rq)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (mirror_count == CAPACITY)
                    st = STATUS_FULL;
                else
                begin
                    if (rq == REQ_PUSH_FRONT)
                    begin
                        mirror_head = (mirror_head + CAPACITY - 1) % CAPACITY;
                        mirror_store[mirror_head] = v;
                    end
                    else
                        mirror_store[ring_slot(mirror_count)] = v;
                    mirror_count++;
                end
            end
            REQ_POP_FRONT:
            begin
                if (mirror_count == 0)
                    st = STATUS_EMPTY;
                else
                begin
                    mirror_head = (mirror_head + 1) % CAPACITY;
                    mirror_count--;
                end
            end
            REQ_POP_BACK:
            begin
                if (mirror_count == 0)
                    st = STATUS_EMPTY;
                else
                    mirror_count--;
            end
            REQ_CLEAR:
            begin
                mirror_count = 0;
                mirror_head  = 0;
            end
            REQ_DELETE:
            begin
                // Remove the first match from the front and close the gap behind it.
                st = STATUS_NOTFOUND;
                for (int i = 0; i < mirror_count && !found; i++)
                begin
                    if (mirror_store[ring_slot(i)] == v)
                    begin
                        for (int j = i; j + 1 < mirror_count; j++)
                            mirror_store[ring_slot(j)] = mirror_store[ring_slot(j + 1)];
                        mirror_count--;
                        st    = STATUS_OK;
                        found = 1'b1;
                    end
                end
            end
            REQ_READ_ALL:
            begin
                reading = 1'b1;
                span    = mirror_count;
            end
            REQ_READ_FIRST:
                reading = 1'b1;
            REQ_READ_LAST:
            begin
                reading = 1'b1;
                first   = mirror_count - span;
            end
            default:
                ;
        endcase

        // A read-out gives a result per entry; an empty one, or any other, gives one status.
        if (!reading || span == 0)
            outq.push_back(make_result(0, 1'b0,
                (reading && mirror_count == 0) ? STATUS_EMPTY : st, 1'b1));
        else
            for (int i = 0; i < span; i++)
                outq.push_back(make_result(mirror_store[ring_slot(first + i)], 1'b1,
                    STATUS_OK, (i + 1 == span)));
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return $signed($urandom_range(6)) - 3;
        else if (roll < 50)
        begin
            case ($urandom_range(3))
                0: return 32'sh80000000;
                1: return 32'sh7FFFFFFF;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    // Send one request, hold it until the transfer, then record what it should cause.
    task automatic issue_request(
        input logic [REQ_W-1:0]          rq,
        input logic signed [VALUE_W-1:0] v,
        input logic [COUNT_IN_W-1:0]     k,
        input logic                      given,
        input logic [STATUS_W-1:0]       given_st
    );
        result_t fresh [$];

        if (!calm && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        value      <= v;
        item_count <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        apply_request(rq, v, k, fresh);
        if (given)
            owed_results.push_back(make_result(0, 1'b0, given_st, 1'b1));
        else
            foreach (fresh[i])
                owed_results.push_back(fresh[i]);

        n_items++;
        if (rq == REQ_READ_ALL || rq == REQ_READ_FIRST || rq == REQ_READ_LAST)
            n_readouts++;
        if (fresh[0].st == STATUS_FULL)
            n_full++;
        if (fresh[0].st == STATUS_NOTFOUND)
            n_missed++;
    endtask

    task automatic push_random();
        issue_request($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value(),
            COUNT_IN_W'($urandom_range(63)), FROM_MODEL, STATUS_OK);
    endtask

    task automatic pop_random();
        issue_request($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, $urandom,
            COUNT_IN_W'($urandom_range(63)), FROM_MODEL, STATUS_OK);
    endtask

    // Hold the input channel idle until every owed result has been transferred.
    task automatic settle_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(
        input string         field,
        input logic [31:0]   want,
        input logic [31:0]   got
    );
        if (want !== got)
        begin
            if (n_errors < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                    $time, field, want, got);
            n_errors++;
        end
    endtask

    // Output stall in random bursts.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Check every result transfer against the oldest owed result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (owed_results.size() == 0)
            begin
                if (n_errors < MAX_REPORTS)
                    $display("%0t ns: unexpected result, value %h has %b status %0d last %b",
                        $time, item_value, has_item, status, last_of_run);
                n_errors++;
            end
            else
            begin
                want = owed_results.pop_front();
                compare_field("item_value", want.item, item_value);
                compare_field("has_item", 32'(want.has), 32'(has_item));
                compare_field("status", 32'(want.st), 32'(status));
                compare_field("last_of_run", 32'(want.last), 32'(last_of_run));
            end
        end
    end

    // Reset, directed table, random traffic, then drain and report.
    initial
    begin
        int unsigned                sent;
        int unsigned                pick;
        int unsigned                extra;
        int unsigned                next_retune;
        int unsigned                next_settle;
        logic signed [VALUE_W-1:0]  target;

        sent        = 0;
        next_retune = 0;
        next_settle = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            issue_request(script[i].rq, script[i].v, script[i].k, script[i].given, script[i].st);

        while (sent < RANDOM_ITEMS)
        begin
            calm = (sent + CALM_ITEMS >= RANDOM_ITEMS);
            if (sent >= next_retune)
            begin
                gap_pct     = pick_pct();
                stall_pct   = pick_pct();
                next_retune += 60;
            end
            if (sent >= next_settle)
            begin
                settle_outputs();
                next_settle += 130;
            end

            pick = $urandom_range(99);
            if (pick < 10)
            begin
                // Fill to capacity, then push once or twice more into a full deque.
                extra = $urandom_range(1, 2);
                while (extra > 0)
                begin
                    if (mirror_count == CAPACITY)
                        extra--;
                    push_random();
                    sent++;
                end
            end
            else if (pick < 17)
            begin
                // Drain to empty, then pop once more.
                extra = 1;
                while (extra > 0)
                begin
                    if (mirror_count == 0)
                        extra--;
                    pop_random();
                    sent++;
                end
            end
            else
            begin
                if (pick < 32)
                    issue_request(readout_codes[$urandom_range(2)], $urandom,
                        COUNT_IN_W'($urandom_range(1) ? $urandom_range(63)
                            : $urandom_range(mirror_count + 1)),
                        FROM_MODEL, STATUS_OK);
                else if (pick < 47)
                begin
                    // Mostly delete a value that is present, sometimes a random one.
                    if (mirror_count != 0 && $urandom_range(99) < 65)
                        target = mirror_store[ring_slot($urandom_range(mirror_count - 1))];
                    else
                        target = pick_value();
                    issue_request(REQ_DELETE, target, COUNT_IN_W'($urandom_range(63)),
                        FROM_MODEL, STATUS_OK);
                end
                else if (pick < 80)
                    push_random();
                else if (pick < 92)
                    pop_random();
                else if (pick < 96)
                    issue_request(REQ_CLEAR, $urandom, COUNT_IN_W'($urandom_range(63)),
                        FROM_MODEL, STATUS_OK);
                else
                    issue_request(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), $urandom,
                        COUNT_IN_W'($urandom_range(63)), FROM_MODEL, STATUS_OK);
                sent++;
            end
        end

        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 8) @(posedge clk);

        $display("Covered %0d requests (%0d read-outs), %0d result transfers checked.",
            n_items, n_readouts, n_results);
        $display("Pushes refused on a full deque: %0d, deletes with no match: %0d.",
            n_full, n_missed);
        if (n_errors == 0)
            $display("bounded_deque_with_delete test passed");
        else
            $display("bounded_deque_with_delete test failed");
        $finish;
    end

endmodule
